FILE: sv/lzw_rle_stream_decoder_macros.svh
// Assertion macros used by the decoder checker.
`ifndef LZW_RLE_STREAM_DECODER_MACROS_SVH
`define LZW_RLE_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LZWR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lzwr check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define LZWR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lzwr check failed");

`endif

FILE: sv/lzwr_pkg.sv
// Types, constants and commands of the LZW and run-length stream decoder.
`default_nettype none
package lzwr_pkg;
  localparam int unsigned MAX_CODE_BITS   = 12;
  localparam int unsigned START_CODE_BITS = 9;
  localparam int unsigned STACK_DEPTH     = 4096;
  localparam int unsigned TABLE_SIZE      = 1 << MAX_CODE_BITS;
  localparam int unsigned CODE_W          = MAX_CODE_BITS;
  localparam int unsigned NFC_W           = CODE_W + 1;
  localparam int unsigned SA_W            = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W            = SA_W + 1;
  localparam int unsigned CW_W            = 5;
  localparam int unsigned FILL_W          = 5;
  localparam int unsigned BO_W            = 8;
  localparam int unsigned BI_W            = $clog2(MAX_CODE_BITS);
  localparam int unsigned BUF_W           = 8 * MAX_CODE_BITS;
  localparam int unsigned CLEAR_CODE      = 256;
  localparam int unsigned FIRST_FREE      = 257;
  localparam logic [7:0]  MARKER_RESET    = 8'd144;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_END   = 2'd1,
    ACT_DRAIN = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DATA       = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_END        = 2'd2,
    ST_REFUSED    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_FILL   = 3'd1,
    PH_GROUP  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_DONE   = 3'd4,
    PH_DEAD   = 3'd5
  } phase_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_EXEC,
    CMD_RL,
    CMD_POP_RD,
    CMD_POP_DONE,
    CMD_DEC0,
    CMD_WALK_RD,
    CMD_WALK_PUSH,
    CMD_FC_RD,
    CMD_FC_DONE,
    CMD_DEC_END,
    CMD_EMIT_END
  } cmd_e;

  typedef struct packed {
    logic exec_emit;
    logic is_drain;
    logic rl_nz;
    logic sp_nz;
    logic busy;
    logic done;
    logic dec_walk;
    logic walk_more;
    logic pop_emit;
    logic out_free;
  } dp_status_t;
endpackage
`default_nettype wire

FILE: sv/lzwr_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module lzwr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

FILE: sv/lzwr_ctrl.sv
// Sequencing state machine of the decoder.
`default_nettype none
module lzwr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lzwr_pkg::dp_status_t st_i,
  output lzwr_pkg::cmd_e      cmd_o
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_EXEC   = 10'b0000000010,
    S_DRAIN  = 10'b0000000100,
    S_POP    = 10'b0000001000,
    S_WALK   = 10'b0000010000,
    S_WPUSH  = 10'b0000100000,
    S_FC     = 10'b0001000000,
    S_DECEND = 10'b0010000000,
    S_SPARE0 = 10'b0100000000,
    S_SPARE1 = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = lzwr_pkg::CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = lzwr_pkg::CMD_LATCH;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st_i.is_drain) begin
          state_d = S_DRAIN;
        end else if (!st_i.exec_emit || st_i.out_free) begin
          cmd_o   = lzwr_pkg::CMD_EXEC;
          state_d = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (st_i.rl_nz) begin
          if (st_i.out_free) begin
            cmd_o   = lzwr_pkg::CMD_RL;
            state_d = S_IDLE;
          end
        end else if (st_i.sp_nz) begin
          cmd_o   = lzwr_pkg::CMD_POP_RD;
          state_d = S_POP;
        end else if (st_i.busy) begin
          cmd_o   = lzwr_pkg::CMD_DEC0;
          state_d = st_i.dec_walk ? S_WALK : S_DECEND;
        end else if (st_i.done) begin
          if (st_i.out_free) begin
            cmd_o   = lzwr_pkg::CMD_EMIT_END;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        if (st_i.out_free) begin
          cmd_o   = lzwr_pkg::CMD_POP_DONE;
          state_d = st_i.pop_emit ? S_IDLE : S_DRAIN;
        end
      end
      S_WALK: begin
        if (st_i.walk_more) begin
          cmd_o   = lzwr_pkg::CMD_WALK_RD;
          state_d = S_WPUSH;
        end else begin
          cmd_o   = lzwr_pkg::CMD_FC_RD;
          state_d = S_FC;
        end
      end
      S_WPUSH: begin
        cmd_o   = lzwr_pkg::CMD_WALK_PUSH;
        state_d = S_WALK;
      end
      S_FC: begin
        cmd_o   = lzwr_pkg::CMD_FC_DONE;
        state_d = S_DECEND;
      end
      S_DECEND: begin
        cmd_o   = lzwr_pkg::CMD_DEC_END;
        state_d = S_DRAIN;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

FILE: sv/lzwr_dp.sv
// Datapath: code unpacking, LZW tables, reverse stack, run-length expander.
`default_nettype none
module lzwr_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lzwr_pkg::cmd_e         cmd_i,
  output lzwr_pkg::dp_status_t   st_o,
  input  logic [1:0]             action_i,
  input  logic [7:0]             in_byte_i,
  input  logic                   cfg_valid_i,
  input  logic [7:0]             cfg_repeat_marker_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic [1:0]             status_o
);
  localparam int unsigned CW = lzwr_pkg::CODE_W;
  localparam int unsigned NW = lzwr_pkg::NFC_W;
  localparam int unsigned SW = lzwr_pkg::SP_W;
  localparam int unsigned SA = lzwr_pkg::SA_W;
  localparam int unsigned FW = lzwr_pkg::FILL_W;
  localparam int unsigned BW = lzwr_pkg::BO_W;
  localparam int unsigned KW = lzwr_pkg::CW_W;
  localparam int unsigned NB = lzwr_pkg::MAX_CODE_BITS;
  localparam int unsigned BI_W = lzwr_pkg::BI_W;

  lzwr_pkg::action_e act_q;
  lzwr_pkg::phase_e  phase_q;
  logic [7:0]    byte_q, mk_q, fc_q, lo_q, rl_q;
  logic [FW-1:0] fill_q;
  logic [BW-1:0] bo_q;
  logic [KW-1:0] cw_q;
  logic [NW-1:0] nfc_q;
  logic [CW-1:0] prev_q, w_q, incode_q;
  logic [SW-1:0] sp_q;
  logic          rs_q, cp_q, started_q, cleared_q;
  logic [7:0]    buf_q [NB];
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  lzwr_pkg::status_e out_status_q;

  logic [lzwr_pkg::BUF_W-1:0]    flat;
  logic [lzwr_pkg::BUF_W+CW-1:0] shifted;
  logic [CW-1:0] code, code_mask, pre_rdata;
  logic [7:0]    suf_rdata, stk_rdata, fc_new, push_val;
  logic          is_clear, push_en, stk_we, tbl_we, tbl_re, pend, busy, dead, header;
  logic          emit, hdr_ok, out_free;
  logic [7:0]    emit_byte;
  lzwr_pkg::status_e emit_status;
  logic [FW-1:0] fill_inc;
  logic [NW-1:0] maxc;
  logic          grow, exhausted;
  logic [KW-1:0] cw_new;
  logic signed [10:0] ex_lhs, ex_rhs;

  lzwr_ram #(.WIDTH(CW), .DEPTH(lzwr_pkg::TABLE_SIZE)) u_prefix (
    .clk_i, .we_i(tbl_we), .waddr_i(nfc_q[CW-1:0]), .wdata_i(prev_q),
    .re_i(tbl_re), .raddr_i(w_q), .rdata_o(pre_rdata)
  );
  lzwr_ram #(.WIDTH(8), .DEPTH(lzwr_pkg::TABLE_SIZE)) u_suffix (
    .clk_i, .we_i(tbl_we), .waddr_i(nfc_q[CW-1:0]), .wdata_i(fc_new),
    .re_i(tbl_re), .raddr_i(w_q), .rdata_o(suf_rdata)
  );
  lzwr_ram #(.WIDTH(8), .DEPTH(lzwr_pkg::STACK_DEPTH)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(sp_q[SA-1:0]), .wdata_i(push_val),
    .re_i(cmd_i == lzwr_pkg::CMD_POP_RD), .raddr_i(SA'(sp_q - 1'b1)),
    .rdata_o(stk_rdata)
  );

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      flat[j*8 +: 8] = buf_q[j];
    end
    for (int i = 0; i < CW; i++) begin
      code_mask[i] = (KW'(i) < cw_q);
    end
    shifted = {{CW{1'b0}}, flat} >> bo_q;
    code    = shifted[CW-1:0] & code_mask;
  end

  assign is_clear = !cp_q && (code == CW'(lzwr_pkg::CLEAR_CODE));
  assign dead     = (phase_q == lzwr_pkg::PH_DEAD);
  assign header   = (phase_q == lzwr_pkg::PH_HEADER);
  assign busy     = (phase_q == lzwr_pkg::PH_GROUP) || (phase_q == lzwr_pkg::PH_TAIL);
  assign pend     = (sp_q != '0) || (rl_q != '0);
  assign hdr_ok   = (byte_q == 8'(lzwr_pkg::MAX_CODE_BITS));
  assign out_free = !out_valid_q || out_ready_i;
  assign fc_new   = (w_q < CW'(256)) ? w_q[7:0] : suf_rdata;
  assign fill_inc = FW'(fill_q + 1'b1);
  assign tbl_re   = (cmd_i == lzwr_pkg::CMD_WALK_RD) || (cmd_i == lzwr_pkg::CMD_FC_RD);
  assign tbl_we   = (cmd_i == lzwr_pkg::CMD_FC_DONE) && (nfc_q < NW'(lzwr_pkg::TABLE_SIZE));

  always_comb begin
    push_en  = 1'b0;
    push_val = fc_q;
    case (cmd_i)
      lzwr_pkg::CMD_DEC0: begin
        push_en  = !started_q || (!is_clear && ({1'b0, code} >= nfc_q));
        push_val = started_q ? fc_q : code[7:0];
      end
      lzwr_pkg::CMD_WALK_PUSH: begin
        push_en  = 1'b1;
        push_val = suf_rdata;
      end
      lzwr_pkg::CMD_FC_DONE: begin
        push_en  = 1'b1;
        push_val = fc_new;
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end
  assign stk_we = push_en && (sp_q < SW'(lzwr_pkg::STACK_DEPTH));

  always_comb begin
    maxc = (cw_q >= KW'(lzwr_pkg::MAX_CODE_BITS)) ? NW'(lzwr_pkg::TABLE_SIZE)
         : NW'((NW'(1) << cw_q) - 1'b1);
    grow = nfc_q > maxc;
    if (cleared_q) begin
      cw_new = KW'(lzwr_pkg::START_CODE_BITS);
    end else if (grow && (cw_q < KW'(lzwr_pkg::MAX_CODE_BITS))) begin
      cw_new = KW'(cw_q + 1'b1);
    end else begin
      cw_new = cw_q;
    end
    ex_lhs    = $signed({3'b000, bo_q});
    ex_rhs    = $signed({3'b000, fill_q, 3'b000}) - $signed({6'd0, cw_new}) + 11'sd1;
    exhausted = ex_lhs >= ex_rhs;
  end

  always_comb begin
    st_o.exec_emit = 1'b0;
    if (dead) begin
      st_o.exec_emit = (act_q != lzwr_pkg::ACT_NONE);
    end else if (header) begin
      st_o.exec_emit = ((act_q == lzwr_pkg::ACT_BYTE) && !hdr_ok) ||
                       (act_q == lzwr_pkg::ACT_END);
    end else begin
      st_o.exec_emit = (act_q == lzwr_pkg::ACT_BYTE) && (pend || busy);
    end
    st_o.is_drain  = (act_q == lzwr_pkg::ACT_DRAIN) && !dead;
    st_o.rl_nz     = (rl_q != '0);
    st_o.sp_nz     = (sp_q != '0);
    st_o.busy      = busy;
    st_o.done      = (phase_q == lzwr_pkg::PH_DONE);
    st_o.dec_walk  = started_q && !is_clear;
    st_o.walk_more = (w_q >= CW'(256)) && (sp_q < SW'(lzwr_pkg::STACK_DEPTH - 1));
    st_o.pop_emit  = rs_q ? (stk_rdata == 8'd0) : (stk_rdata != mk_q);
    st_o.out_free  = out_free;
  end

  always_comb begin
    emit        = 1'b0;
    emit_byte   = 8'd0;
    emit_status = lzwr_pkg::ST_DATA;
    case (cmd_i)
      lzwr_pkg::CMD_EXEC: begin
        emit = st_o.exec_emit;
        if (dead) begin
          emit_status = lzwr_pkg::ST_END;
        end else if (header) begin
          emit_status = lzwr_pkg::ST_BAD_HEADER;
        end else begin
          emit_status = lzwr_pkg::ST_REFUSED;
        end
      end
      lzwr_pkg::CMD_RL: begin
        emit      = 1'b1;
        emit_byte = lo_q;
      end
      lzwr_pkg::CMD_POP_DONE: begin
        emit      = st_o.pop_emit;
        emit_byte = rs_q ? mk_q : stk_rdata;
      end
      lzwr_pkg::CMD_EMIT_END: begin
        emit        = 1'b1;
        emit_status = lzwr_pkg::ST_END;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == lzwr_pkg::CMD_LATCH) begin
      byte_q <= in_byte_i;
    end
    if (emit) begin
      out_byte_q   <= emit_byte;
      out_status_q <= emit_status;
    end
    if (cmd_i == lzwr_pkg::CMD_DEC0) begin
      incode_q <= code;
    end
    if ((cmd_i == lzwr_pkg::CMD_EXEC) && (act_q == lzwr_pkg::ACT_BYTE) &&
        (phase_q == lzwr_pkg::PH_FILL) && !pend && (fill_q < FW'(cw_q)) &&
        (fill_q < FW'(NB))) begin
      buf_q[fill_q[BI_W-1:0]] <= byte_q;
    end
    if ((cmd_i == lzwr_pkg::CMD_EXEC) && (act_q == lzwr_pkg::ACT_END) &&
        (phase_q == lzwr_pkg::PH_FILL)) begin
      for (int j = 0; j < NB; j++) begin
        if (FW'(j) >= fill_q) begin
          buf_q[j] <= 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= lzwr_pkg::ACT_NONE;
      phase_q     <= lzwr_pkg::PH_HEADER;
      mk_q        <= lzwr_pkg::MARKER_RESET;
      fc_q        <= '0;
      lo_q        <= '0;
      rl_q        <= '0;
      fill_q      <= '0;
      bo_q        <= '0;
      cw_q        <= KW'(lzwr_pkg::START_CODE_BITS);
      nfc_q       <= NW'(lzwr_pkg::FIRST_FREE);
      prev_q      <= '0;
      w_q         <= '0;
      sp_q        <= '0;
      rs_q        <= 1'b0;
      cp_q        <= 1'b0;
      started_q   <= 1'b0;
      cleared_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mk_q <= cfg_repeat_marker_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (stk_we) begin
        sp_q <= SW'(sp_q + 1'b1);
      end
      case (cmd_i)
        lzwr_pkg::CMD_LATCH: begin
          act_q <= lzwr_pkg::action_e'(action_i);
        end
        lzwr_pkg::CMD_EXEC: begin
          if (!dead) begin
            case (act_q)
              lzwr_pkg::ACT_BYTE: begin
                if (header) begin
                  phase_q <= hdr_ok ? lzwr_pkg::PH_FILL : lzwr_pkg::PH_DEAD;
                end else if (!pend && (phase_q == lzwr_pkg::PH_FILL)) begin
                  if ((fill_q < FW'(cw_q)) && (fill_q < FW'(NB))) begin
                    fill_q <= fill_inc;
                    if (fill_inc >= FW'(cw_q)) begin
                      bo_q    <= '0;
                      phase_q <= lzwr_pkg::PH_GROUP;
                    end
                  end else if (fill_q >= FW'(cw_q)) begin
                    bo_q    <= '0;
                    phase_q <= lzwr_pkg::PH_GROUP;
                  end
                end
              end
              lzwr_pkg::ACT_END: begin
                if (header) begin
                  phase_q <= lzwr_pkg::PH_DEAD;
                end else if (phase_q == lzwr_pkg::PH_FILL) begin
                  if (fill_q == '0) begin
                    phase_q <= lzwr_pkg::PH_DONE;
                  end else begin
                    bo_q    <= '0;
                    phase_q <= lzwr_pkg::PH_TAIL;
                  end
                end else if (phase_q == lzwr_pkg::PH_GROUP) begin
                  phase_q <= lzwr_pkg::PH_TAIL;
                end
              end
              default: begin
                phase_q <= phase_q;
              end
            endcase
          end
        end
        lzwr_pkg::CMD_RL: begin
          rl_q <= rl_q - 1'b1;
        end
        lzwr_pkg::CMD_POP_RD: begin
          sp_q <= SW'(sp_q - 1'b1);
        end
        lzwr_pkg::CMD_POP_DONE: begin
          if (!rs_q) begin
            if (stk_rdata == mk_q) begin
              rs_q <= 1'b1;
            end else begin
              lo_q <= stk_rdata;
            end
          end else begin
            rs_q <= 1'b0;
            if (stk_rdata != 8'd0) begin
              rl_q <= stk_rdata - 1'b1;
            end
          end
        end
        lzwr_pkg::CMD_DEC0: begin
          bo_q      <= BW'(bo_q + BW'(cw_q));
          cleared_q <= 1'b0;
          if (!started_q) begin
            started_q <= 1'b1;
            fc_q      <= code[7:0];
            prev_q    <= code;
          end else if (is_clear) begin
            cp_q      <= 1'b1;
            nfc_q     <= NW'(lzwr_pkg::CLEAR_CODE);
            cleared_q <= 1'b1;
          end else begin
            cp_q <= 1'b0;
            w_q  <= ({1'b0, code} >= nfc_q) ? prev_q : code;
          end
        end
        lzwr_pkg::CMD_WALK_PUSH: begin
          w_q <= pre_rdata;
        end
        lzwr_pkg::CMD_FC_DONE: begin
          fc_q   <= fc_new;
          prev_q <= incode_q;
          if (tbl_we) begin
            nfc_q <= NW'(nfc_q + 1'b1);
          end
        end
        lzwr_pkg::CMD_DEC_END: begin
          cw_q <= cw_new;
          if (grow || cleared_q || exhausted) begin
            fill_q  <= '0;
            bo_q    <= '0;
            phase_q <= (phase_q == lzwr_pkg::PH_TAIL) ? lzwr_pkg::PH_DONE
                                                        : lzwr_pkg::PH_FILL;
          end
        end
        default: begin
          act_q <= act_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = out_status_q;
endmodule
`default_nettype wire

FILE: sv/lzw_rle_stream_decoder.sv
// Top level of the LZW stream decoder with run-length expansion.
// A byte, end mark or unused action is latched, then executed with its result registered.
// A drain tick emits a pending repeat, else pops the stack in S_POP, marker and count pops
// included, and runs the decodes this triggers; a full output stalls it. A code is decoded
// in S_DRAIN, S_WALK and S_WPUSH per chain step, S_FC, S_DECEND; a first or clear code skips
// to S_DECEND. Input is taken in S_IDLE only. Reset spares RAMs, code buffer, output data.
`default_nettype none
module lzw_rle_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_repeat_marker_i
);
  lzwr_pkg::cmd_e       cmd;
  lzwr_pkg::dp_status_t st;

  assign cfg_ready_o = 1'b1;

  lzwr_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .st_i(st), .cmd_o(cmd)
  );

  lzwr_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .st_o(st), .action_i, .in_byte_i,
    .cfg_valid_i, .cfg_repeat_marker_i, .out_valid_o, .out_ready_i,
    .out_byte_o, .status_o
  );
endmodule
`default_nettype wire

FILE: sv/lzwr_checker.sv
// Port-level checker of the decoder and its bind.
`default_nettype none
`include "lzw_rle_stream_decoder_macros.svh"
module lzwr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] status_o
);
  logic dead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q <= 1'b0;
    end else if (out_valid_o && out_ready_i && (status_o == lzwr_pkg::ST_BAD_HEADER)) begin
      dead_q <= 1'b1;
    end
  end

  `LZWR_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `LZWR_ASSERT_IMP(a_zero_byte, out_valid_o && (status_o != lzwr_pkg::ST_DATA), out_byte_o == 8'd0)
  `LZWR_ASSERT_IMP(a_dead_sticky, out_valid_o && dead_q, status_o == lzwr_pkg::ST_END)
endmodule

bind lzw_rle_stream_decoder lzwr_checker u_chk (.*);
`default_nettype wire
